[sv/tbb_pkg.sv]
// Package for the timer bank: table entry layout, command and result codes,
// and the sequencer states. No dependencies.
`default_nettype none
package tbb_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_DELAY  = 2'd1,
        CMD_REPEAT = 2'd2,
        CMD_STOP   = 2'd3
    } tbb_cmd_t;

    localparam logic [2:0] KIND_DELAY_FIRED  = 3'd0;
    localparam logic [2:0] KIND_REPEAT_FIRED = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED     = 3'd2;
    localparam logic [2:0] KIND_FULL         = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND    = 3'd4;

    typedef struct packed {
        logic [31:0] start;
        logic [30:0] length;
        logic        act;
        logic [7:0]  tag;
    } tbb_entry_t;

    localparam int EntryBits = $bits(tbb_entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_RD,
        ST_D_CHK,
        ST_D_SH_RD,
        ST_D_SH_WR,
        ST_R_RD,
        ST_R_CHK,
        ST_S_RD,
        ST_S_CHK,
        ST_S_SH_RD,
        ST_S_SH_WR,
        ST_FIN
    } tbb_state_t;

endpackage
`default_nettype wire

[sv/tbb_ram.sv]
// Single-port-write, single-port-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module tbb_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 72
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sv/one_shot_and_periodic_timer_bank.sv]
// Timer bank top level: command sequencer over the delay and repeat tables.
// Depends on tbb_pkg and tbb_ram.
`default_nettype none
// Create commands answer in the cycle after the request; a full table is
// reported the same way. Stop scans the repeat table entry by entry and
// then moves each later entry up. A tick scans the delay table, moves up
// the entries after the first expired one, then scans the repeat table;
// each step is one read of a table RAM and a state that uses its data.
// Reset clears time, counts and control state; table contents are not
// cleared. The receiver cannot stall: each result shows for one cycle.
module one_shot_and_periodic_timer_bank #(
    parameter int DELAY_SLOTS  = 16,
    parameter int REPEAT_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [30:0] amount,
    input  wire logic [7:0]  tag,
    input  wire logic        has_action,
    output logic             strobe,
    output logic      [2:0]  kind,
    output logic      [7:0]  event_tag,
    output logic             last
);
    import tbb_pkg::*;

    localparam int DCW = $clog2(DELAY_SLOTS + 1);
    localparam int RCW = $clog2(REPEAT_SLOTS + 1);
    localparam int DAW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
    localparam int RAW = (REPEAT_SLOTS > 1) ? $clog2(REPEAT_SLOTS) : 1;
    // one index serves both tables
    localparam int CW  = (DCW > RCW) ? DCW : RCW;

    tbb_state_t state_reg, state_next;
    logic [31:0]  time_reg, time_next;
    logic [DCW-1:0] dcount_reg, dcount_next;
    logic [RCW-1:0] rcount_reg, rcount_next;
    logic [CW-1:0]  idx_reg, idx_next, idx_inc;
    logic [7:0]     stag_reg, stag_next;
    logic           pend_v_reg, pend_v_next;
    logic [2:0]     pend_k_reg, pend_k_next;
    logic [7:0]     pend_t_reg, pend_t_next;
    logic           out_v_reg, out_v_next;
    logic [2:0]     out_k_reg, out_k_next;
    logic [7:0]     out_t_reg, out_t_next;
    logic           out_l_reg, out_l_next;

    // new result found this cycle
    logic           res_v;
    logic [2:0]     res_k;
    logic [7:0]     res_t;

    logic           dwe, rwe;
    logic [DAW-1:0] dwaddr, draddr;
    logic [RAW-1:0] rwaddr, rraddr;
    tbb_entry_t     dwdata, rwdata, drdata, rrdata, new_entry;
    logic [31:0]    d_elapsed, r_elapsed;
    logic           d_expired, r_expired;

    tbb_ram #(.DEPTH(DELAY_SLOTS), .AW(DAW), .W(EntryBits)) u_dram (
        .clk   (clk),
        .we    (dwe),
        .waddr (dwaddr),
        .wdata (dwdata),
        .raddr (draddr),
        .rdata (drdata)
    );

    tbb_ram #(.DEPTH(REPEAT_SLOTS), .AW(RAW), .W(EntryBits)) u_rram (
        .clk   (clk),
        .we    (rwe),
        .waddr (rwaddr),
        .wdata (rwdata),
        .raddr (rraddr),
        .rdata (rrdata)
    );

    assign idx_inc   = idx_reg + CW'(1);
    // elapsed time wraps modulo 2^32, then compares unsigned with the length
    assign d_elapsed = time_reg - drdata.start;
    assign r_elapsed = time_reg - rrdata.start;
    assign d_expired = d_elapsed >= {1'b0, drdata.length};
    assign r_expired = r_elapsed >= {1'b0, rrdata.length};

    assign new_entry = '{start: time_reg, length: amount, act: has_action, tag: tag};

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = out_v_reg;
    assign kind      = out_k_reg;
    assign event_tag = out_t_reg;
    assign last      = out_l_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            time_reg   <= '0;
            dcount_reg <= '0;
            rcount_reg <= '0;
            idx_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            time_reg   <= time_next;
            dcount_reg <= dcount_next;
            rcount_reg <= rcount_next;
            idx_reg    <= idx_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stag_reg   <= stag_next;
        pend_k_reg <= pend_k_next;
        pend_t_reg <= pend_t_next;
        out_k_reg  <= out_k_next;
        out_t_reg  <= out_t_next;
        out_l_reg  <= out_l_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        time_next   = time_reg;
        dcount_next = dcount_reg;
        rcount_next = rcount_reg;
        idx_next    = idx_reg;
        stag_next   = stag_reg;
        pend_v_next = pend_v_reg;
        pend_k_next = pend_k_reg;
        pend_t_next = pend_t_reg;
        out_v_next  = 1'b0;
        out_k_next  = out_k_reg;
        out_t_next  = out_t_reg;
        out_l_next  = out_l_reg;
        res_v       = 1'b0;
        res_k       = KIND_ACCEPTED;
        res_t       = stag_reg;
        dwe         = 1'b0;
        rwe         = 1'b0;
        dwaddr      = idx_reg[DAW-1:0];
        rwaddr      = idx_reg[RAW-1:0];
        draddr      = idx_reg[DAW-1:0];
        rraddr      = idx_reg[RAW-1:0];
        dwdata      = drdata;
        rwdata      = rrdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    stag_next = tag;
                    idx_next  = '0;
                    unique case (tbb_cmd_t'(cmd))
                        CMD_TICK:
                        begin
                            time_next = time_reg + 32'd1;
                            if (dcount_reg != '0)
                                state_next = ST_D_RD;
                            else if (rcount_reg != '0)
                                state_next = ST_R_RD;
                            else
                                state_next = ST_FIN;
                        end
                        CMD_DELAY:
                        begin
                            out_v_next = 1'b1;
                            out_t_next = tag;
                            out_l_next = 1'b1;
                            if (dcount_reg >= DCW'(DELAY_SLOTS))
                                out_k_next = KIND_FULL;
                            else
                            begin
                                out_k_next  = KIND_ACCEPTED;
                                dwe         = 1'b1;
                                dwaddr      = dcount_reg[DAW-1:0];
                                dwdata      = new_entry;
                                dcount_next = dcount_reg + DCW'(1);
                            end
                        end
                        CMD_REPEAT:
                        begin
                            out_v_next = 1'b1;
                            out_t_next = tag;
                            out_l_next = 1'b1;
                            if (rcount_reg >= RCW'(REPEAT_SLOTS))
                                out_k_next = KIND_FULL;
                            else
                            begin
                                out_k_next  = KIND_ACCEPTED;
                                rwe         = 1'b1;
                                rwaddr      = rcount_reg[RAW-1:0];
                                rwdata      = new_entry;
                                rcount_next = rcount_reg + RCW'(1);
                            end
                        end
                        CMD_STOP:
                        begin
                            if (rcount_reg != '0)
                                state_next = ST_S_RD;
                            else
                            begin
                                out_v_next = 1'b1;
                                out_k_next = KIND_NOT_FOUND;
                                out_t_next = tag;
                                out_l_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_D_RD:
            begin
                state_next = ST_D_CHK;
            end
            ST_D_CHK:
            begin
                if (d_expired)
                begin
                    // first expired delay: drop it and close the gap
                    res_v       = drdata.act;
                    res_k       = KIND_DELAY_FIRED;
                    res_t       = drdata.tag;
                    dcount_next = dcount_reg - DCW'(1);
                    if (idx_inc < CW'(dcount_reg))
                        state_next = ST_D_SH_RD;
                    else
                    begin
                        idx_next   = '0;
                        state_next = (rcount_reg != '0) ? ST_R_RD : ST_FIN;
                    end
                end
                else if (idx_inc < CW'(dcount_reg))
                begin
                    idx_next   = idx_inc;
                    state_next = ST_D_RD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = (rcount_reg != '0) ? ST_R_RD : ST_FIN;
                end
            end
            ST_D_SH_RD:
            begin
                draddr     = idx_inc[DAW-1:0];
                state_next = ST_D_SH_WR;
            end
            ST_D_SH_WR:
            begin
                dwe    = 1'b1;
                dwdata = drdata;
                if (idx_inc < CW'(dcount_reg))
                begin
                    idx_next   = idx_inc;
                    state_next = ST_D_SH_RD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = (rcount_reg != '0) ? ST_R_RD : ST_FIN;
                end
            end
            ST_R_RD:
            begin
                state_next = ST_R_CHK;
            end
            ST_R_CHK:
            begin
                if (r_expired)
                begin
                    res_v  = rrdata.act;
                    res_k  = KIND_REPEAT_FIRED;
                    res_t  = rrdata.tag;
                    rwe    = 1'b1;
                    rwdata = '{start: time_reg, length: rrdata.length,
                               act: rrdata.act, tag: rrdata.tag};
                end
                idx_next   = idx_inc;
                state_next = (idx_inc < CW'(rcount_reg)) ? ST_R_RD : ST_FIN;
            end
            ST_S_RD:
            begin
                state_next = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                if (rrdata.tag == stag_reg)
                begin
                    res_v       = 1'b1;
                    res_k       = KIND_ACCEPTED;
                    rcount_next = rcount_reg - RCW'(1);
                    state_next  = (idx_inc < CW'(rcount_reg)) ? ST_S_SH_RD : ST_FIN;
                end
                else if (idx_inc < CW'(rcount_reg))
                begin
                    idx_next   = idx_inc;
                    state_next = ST_S_RD;
                end
                else
                begin
                    res_v      = 1'b1;
                    res_k      = KIND_NOT_FOUND;
                    state_next = ST_FIN;
                end
            end
            ST_S_SH_RD:
            begin
                rraddr     = idx_inc[RAW-1:0];
                state_next = ST_S_SH_WR;
            end
            ST_S_SH_WR:
            begin
                rwe    = 1'b1;
                rwdata = rrdata;
                if (idx_inc < CW'(rcount_reg))
                begin
                    idx_next   = idx_inc;
                    state_next = ST_S_SH_RD;
                end
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // release the held result as the final one
                if (pend_v_reg)
                begin
                    out_v_next = 1'b1;
                    out_k_next = pend_k_reg;
                    out_t_next = pend_t_reg;
                    out_l_next = 1'b1;
                end
                pend_v_next = 1'b0;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase

        // hold each new result in the pend registers so the final one can carry last
        if (res_v)
        begin
            if (pend_v_reg)
            begin
                out_v_next = 1'b1;
                out_k_next = pend_k_reg;
                out_t_next = pend_t_reg;
                out_l_next = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_k_next = res_k;
            pend_t_next = res_t;
        end
    end

    a_dcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcount_reg <= DCW'(DELAY_SLOTS))
        else $error("delay count beyond table size");

    a_rcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= RCW'(REPEAT_SLOTS))
        else $error("repeat count beyond table size");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !pend_v_reg)
        else $error("result still held after final result");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("held result left over in idle");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_RD) |-> (rcount_reg != '0))
        else $error("stop scan over empty repeat table");

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for the one-shot and periodic timer bank: drives create, stop and
// tick requests, predicts fired events and acknowledges, checks every result.
// Depends on tbb_pkg and one_shot_and_periodic_timer_bank.
`timescale 1ns / 1ps
module tb;
    import tbb_pkg::*;

    localparam int SLOTS      = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [30:0] amount;
        logic [7:0]  tag;
        logic        act;
    } request_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tag;
        logic       last;
    } event_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [30:0] amount;
    logic [7:0]  tag;
    logic        has_action;
    logic        strobe;
    logic [2:0]  kind;
    logic [7:0]  event_tag;
    logic        last;

    // Predictor copy of the two timer tables.
    logic [31:0] now_ticks;
    int          n_delays;
    int          n_repeats;
    logic [31:0] delay_begin [SLOTS];
    logic [30:0] delay_len   [SLOTS];
    logic [8:0]  delay_id    [SLOTS];
    logic [31:0] repeat_prev [SLOTS];
    logic [30:0] repeat_len  [SLOTS];
    logic [8:0]  repeat_id   [SLOTS];

    request_t pending_requests[$];
    event_t   expected_events[$];
    event_t   step_events[$];
    int       mismatches;
    int       quiet_cycles;

    one_shot_and_periodic_timer_bank dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .amount(amount), .tag(tag), .has_action(has_action),
        .strobe(strobe), .kind(kind), .event_tag(event_tag), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string what);
    begin
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    end
    endtask

    // Append one event of the current request to the step list.
    task automatic note_event(input logic [2:0] k, input logic [7:0] t);
        event_t e;
    begin
        e.kind = k;
        e.tag  = t;
        e.last = 1'b0;
        step_events.insert(step_events.size(), e);
    end
    endtask

    // Advance the timer model by one request and queue the events it causes.
    task automatic predict_events(input request_t r);
        logic [31:0] age;
        int hit;
    begin
        hit = -1;
        step_events.delete();
        case (tbb_cmd_t'(r.cmd))
            CMD_TICK:
            begin
                now_ticks = now_ticks + 32'd1;
                for (int i = 0; i < n_delays; i++)
                begin
                    age = now_ticks - delay_begin[i];
                    if (age >= {1'b0, delay_len[i]})
                    begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0)
                begin
                    if (delay_id[hit][8])
                        note_event(KIND_DELAY_FIRED, delay_id[hit][7:0]);
                    for (int j = hit; j < n_delays - 1; j++)
                    begin
                        delay_begin[j] = delay_begin[j+1];
                        delay_len[j]   = delay_len[j+1];
                        delay_id[j]    = delay_id[j+1];
                    end
                    n_delays--;
                end
                for (int i = 0; i < n_repeats; i++)
                begin
                    age = now_ticks - repeat_prev[i];
                    if (age >= {1'b0, repeat_len[i]})
                    begin
                        if (repeat_id[i][8])
                            note_event(KIND_REPEAT_FIRED, repeat_id[i][7:0]);
                        repeat_prev[i] = now_ticks;
                    end
                end
            end
            CMD_DELAY:
                if (n_delays >= SLOTS)
                    note_event(KIND_FULL, r.tag);
                else
                begin
                    delay_begin[n_delays] = now_ticks;
                    delay_len[n_delays]   = r.amount;
                    delay_id[n_delays]    = {r.act, r.tag};
                    n_delays++;
                    note_event(KIND_ACCEPTED, r.tag);
                end
            CMD_REPEAT:
                if (n_repeats >= SLOTS)
                    note_event(KIND_FULL, r.tag);
                else
                begin
                    repeat_prev[n_repeats] = now_ticks;
                    repeat_len[n_repeats]  = r.amount;
                    repeat_id[n_repeats]   = {r.act, r.tag};
                    n_repeats++;
                    note_event(KIND_ACCEPTED, r.tag);
                end
            default:
            begin
                // Stop matches on the tag only, never on the action flag.
                for (int i = 0; i < n_repeats; i++)
                    if (repeat_id[i][7:0] == r.tag)
                    begin
                        hit = i;
                        break;
                    end
                if (hit >= 0)
                begin
                    for (int j = hit; j < n_repeats - 1; j++)
                    begin
                        repeat_prev[j] = repeat_prev[j+1];
                        repeat_len[j]  = repeat_len[j+1];
                        repeat_id[j]   = repeat_id[j+1];
                    end
                    n_repeats--;
                    note_event(KIND_ACCEPTED, r.tag);
                end
                else
                    note_event(KIND_NOT_FOUND, r.tag);
            end
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size()-1].last = 1'b1;
        foreach (step_events[k])
            expected_events.insert(expected_events.size(), step_events[k]);
    end
    endtask

    function automatic int gap_cycles();
    begin
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    end
    endfunction

    function automatic request_t make_request(input logic [1:0] c, input logic [30:0] a,
                                              input logic [7:0] t, input logic h);
        request_t r;
    begin
        r.cmd = c;
        r.amount = a;
        r.tag = t;
        r.act = h;
        return r;
    end
    endfunction

    // Short amounts mostly, so entries fire within the run; a few are huge.
    function automatic logic [30:0] pick_amount();
    begin
        case ($urandom_range(0, 9))
            0: return 31'h7fffffff;
            1: return 31'($urandom());
            2: return 31'd0;
            default: return 31'($urandom_range(1, 12));
        endcase
    end
    endfunction

    task automatic load_next();
        request_t r;
    begin
        r = pending_requests.pop_front();
        start      <= 1'b1;
        cmd        <= r.cmd;
        amount     <= r.amount;
        tag        <= r.tag;
        has_action <= r.act;
    end
    endtask

    int   gap_left;
    logic busy_at_edge;

    // Driver: hold start until the request is taken, then draw a gap.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= CMD_TICK;
            amount     <= '0;
            tag        <= '0;
            has_action <= 1'b0;
            gap_left   <= 0;
        end
        else if (start && !busy_at_edge)
        begin
            // Previous request was accepted on the last rising edge.
            if (gap_left == 0 && pending_requests.size() > 0 && gap_cycles() == 0)
                load_next();
            else
            begin
                start    <= 1'b0;
                gap_left <= gap_cycles();
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_requests.size() > 0)
                load_next();
        end
    end

    // Monitor: predict on acceptance, check each strobed result.
    always @(posedge clk or negedge rst_n)
    begin
        event_t want;
        logic   active;
        if (!rst_n)
        begin
            busy_at_edge <= 1'b1;
            quiet_cycles <= 0;
        end
        else
        begin
            busy_at_edge <= busy;
            active = (start && !busy) || strobe;
            if (start && !busy)
                predict_events(make_request(cmd, amount, tag, has_action));
            if (strobe)
            begin
                if (expected_events.size() == 0)
                    report($sformatf("unexpected result kind %0d tag %0d", kind, event_tag));
                else
                begin
                    want = expected_events.pop_front();
                    if (kind !== want.kind)
                        report($sformatf("kind %0d, want %0d", kind, want.kind));
                    if (event_tag !== want.tag)
                        report($sformatf("tag %0d, want %0d", event_tag, want.tag));
                    if (last !== want.last)
                        report($sformatf("last %0b, want %0b", last, want.last));
                end
            end
            if (active)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int c;
        logic [7:0] t;
        now_ticks = '0;
        n_delays = 0;
        n_repeats = 0;
        mismatches = 0;
        rst_n = 1'b0;

        // Directed: extremes, silent entries, zero length, full tables, stops.
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_TICK, 31'd0, 8'd0, 1'b0));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_STOP, 31'd0, 8'hff, 1'b1));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_DELAY, 31'd0, 8'h00, 1'b1));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_DELAY, 31'd0, 8'hff, 1'b0));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_DELAY, 31'h7fffffff, 8'h5a, 1'b1));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_REPEAT, 31'd0, 8'ha5, 1'b1));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_REPEAT, 31'd1, 8'h11, 1'b0));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_TICK, 31'h7fffffff, 8'hff, 1'b1));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_TICK, 31'd0, 8'd0, 1'b0));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_STOP, 31'd0, 8'h11, 1'b0));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_STOP, 31'd0, 8'ha5, 1'b0));
        for (int i = 0; i < 17; i++)
            pending_requests.insert(pending_requests.size(),
                                    make_request(CMD_REPEAT, 31'd2, 8'(i), 1'(i)));
        for (int i = 0; i < 16; i++)
            pending_requests.insert(pending_requests.size(),
                                    make_request(CMD_DELAY, 31'(i), 8'(i), 1'b1));
        pending_requests.insert(pending_requests.size(),
                                make_request(CMD_DELAY, 31'd1, 8'h77, 1'b1));
        for (int i = 0; i < 20; i++)
            pending_requests.insert(pending_requests.size(),
                                    make_request(CMD_TICK, 31'($urandom()), 8'd0, 1'b0));
        for (int i = 0; i < 16; i++)
            pending_requests.insert(pending_requests.size(),
                                    make_request(CMD_STOP, 31'd0, 8'(i), 1'b0));

        // Random: mostly ticks and creates, stops aimed at small tag set.
        for (int i = 0; i < 220; i++)
        begin
            c = $urandom_range(0, 9);
            t = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
            if (c < 4)
                pending_requests.insert(pending_requests.size(),
                    make_request(CMD_TICK, 31'($urandom()), t, 1'($urandom())));
            else if (c < 6)
                pending_requests.insert(pending_requests.size(),
                    make_request(CMD_DELAY, pick_amount(), t, 1'($urandom_range(0, 3) != 0)));
            else if (c < 8)
                pending_requests.insert(pending_requests.size(),
                    make_request(CMD_REPEAT, pick_amount(), t, 1'($urandom_range(0, 3) != 0)));
            else
                pending_requests.insert(pending_requests.size(),
                    make_request(CMD_STOP, 31'($urandom()), t, 1'($urandom())));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || start)
            @(posedge clk);
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[one_shot_and_periodic_timer_bank.f]
sv/tbb_pkg.sv
sv/tbb_ram.sv
sv/one_shot_and_periodic_timer_bank.sv
tb/tb.sv
